>>> hw/rtl/wlh_pkg.sv
// Shared types and constants for the word length histogram block.
// Standalone package; used by word_length_histogram.
package wlh_pkg;

  localparam int NUM_BINS    = 16;
  localparam int COUNT_WIDTH = 20;
  localparam int LEN_W       = 7;
  localparam int BAR_W       = 7;
  localparam int CHAR_W      = 8;
  localparam int BIN_AW      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int NUM_W       = COUNT_WIDTH + BAR_W;
  localparam int STEP_W      = $clog2(BAR_W);

  localparam logic [LEN_W-1:0]       LEN_MAX   = {LEN_W{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

  localparam logic ACT_TEXT   = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  typedef struct packed {
    logic              action;
    logic [CHAR_W-1:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]       word_length;
    logic [COUNT_WIDTH-1:0] word_count;
    logic [BAR_W-1:0]       bar_length;
    logic [COUNT_WIDTH-1:0] overflow_words;
    logic                   last_bin;
  } out_item_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_WIDTH'(1);
  endfunction

endpackage

>>> hw/rtl/word_length_histogram.sv
// Word length histogram: top level with the bin memory and report sequencer.
// Depends on wlh_pkg for types, widths and character codes.
//
// Usage:
//   An item is taken at a rising edge where start is high and busy is low.
//   A text item (action 0) carries one byte; space, tab and newline end a
//   word, and the bin for the word length is incremented in a one-entry
//   read-modify-write of the bin memory. Text items can be taken in every
//   cycle while busy is low: two word ends always have a word byte between
//   them, so the write-back of one never meets the read of the next. Text
//   items give no result and never raise busy.
//   An end-of-text item (action 1) raises busy and starts the report. A
//   first pass reads all bins to find the largest count, a second pass
//   reads each bin again and divides count * max_bar_height by that peak
//   with a one-bit-a-cycle divider. Each result is shown for one cycle
//   with result_strobe, the last with last_bin set. All counters clear as
//   the last result is registered.
//   The receiver cannot stall; results must be taken when strobed.
//   Reset clears the bin valid flags, the overflow count and the word
//   tracker, and sets max_bar_height to 16. The register may be written
//   through cfg_wr_en / cfg_wr_data only while the block is idle.
module word_length_histogram
  import wlh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  in_item_t         cmd,
  output logic             busy,
  input  logic             cfg_wr_en,
  input  logic [BAR_W-1:0] cfg_wr_data,
  output logic             result_strobe,
  output out_item_t        result
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PK_RD  = 6'b000010,
    S_PK_ACC = 6'b000100,
    S_BIN_RD = 6'b001000,
    S_BIN_LD = 6'b010000,
    S_DIV    = 6'b100000
  } state_t;

  state_t state;

  logic [BAR_W-1:0]       max_bar_height;
  logic [COUNT_WIDTH-1:0] overflow_count;
  logic                   inside_word;
  logic [LEN_W-1:0]       current_length;

  // Bin memory with one valid flag per entry; an invalid entry reads as zero.
  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]    bin_valid;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   rd_valid;
  logic                   rd_en;
  logic [BIN_AW-1:0]      rd_addr;
  logic                   wr_pend;
  logic [BIN_AW-1:0]      wr_addr;
  logic [COUNT_WIDTH-1:0] count_rd;

  logic [BIN_AW-1:0]      idx;
  logic [COUNT_WIDTH-1:0] peak;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [NUM_W-1:0]       num;
  logic [NUM_W-1:0]       dsh;
  logic [BAR_W-1:0]       quot;
  logic [STEP_W-1:0]      step;

  logic             accept;
  logic             is_sep;
  logic             word_end;
  logic             in_range;
  logic             div_ge;
  logic [BAR_W-1:0] quot_next;
  logic [BAR_W-1:0] bar;
  logic             idx_last;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign is_sep   = (cmd.char_code == CHAR_SPACE) || (cmd.char_code == CHAR_TAB) ||
                    (cmd.char_code == CHAR_NEWLINE);
  assign word_end = accept && (cmd.action == ACT_TEXT) && is_sep && inside_word;
  assign in_range = (current_length >= LEN_W'(1)) &&
                    (current_length <= LEN_W'(NUM_BINS));
  assign count_rd = rd_valid ? rd_data : '0;
  assign idx_last = (idx == BIN_AW'(NUM_BINS - 1));

  assign div_ge    = (num >= dsh);
  assign quot_next = {quot[BAR_W-2:0], div_ge};
  always_comb begin
    if (cur_cnt == '0) begin
      bar = '0;
    end else if (quot_next == '0) begin
      bar = BAR_W'(1);
    end else begin
      bar = quot_next;
    end
  end

  always_comb begin
    if (state == S_IDLE) begin
      rd_en   = word_end && in_range;
      rd_addr = BIN_AW'(current_length - LEN_W'(1));
    end else begin
      rd_en   = (state == S_PK_RD) || (state == S_BIN_RD);
      rd_addr = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_pend) begin
      mem[wr_addr] <= sat_inc(count_rd);
    end
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= bin_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
    end else if (state == S_DIV && step == '0 && idx_last) begin
      bin_valid <= '0;
    end else if (wr_pend) begin
      bin_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bar_height <= BAR_W'(16);
    end else if (cfg_wr_en) begin
      max_bar_height <= cfg_wr_data;
    end
  end

  // Text path: track the open word, count words too long for a bin and schedule the bin update.
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_word    <= 1'b0;
      current_length <= '0;
      wr_pend        <= 1'b0;
      overflow_count <= '0;
    end else begin
      wr_pend <= word_end && in_range;
      if (accept && cmd.action == ACT_REPORT) begin
        inside_word    <= 1'b0;
        current_length <= '0;
      end else if (accept) begin
        if (is_sep) begin
          if (inside_word) begin
            if (!in_range) begin
              overflow_count <= sat_inc(overflow_count);
            end
            inside_word    <= 1'b0;
            current_length <= '0;
          end
        end else begin
          inside_word <= 1'b1;
          if (current_length != LEN_MAX) begin
            current_length <= current_length + LEN_W'(1);
          end
        end
      end
      if (state == S_DIV && step == '0 && idx_last) begin
        overflow_count <= '0;
      end
    end
    if (rd_en && state == S_IDLE) begin
      wr_addr <= rd_addr;
    end
  end

  // Report sequencer: peak pass, then per-bin divide and emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (state == S_DIV) && (step == '0);
      unique case (state)
        S_IDLE: begin
          if (accept && cmd.action == ACT_REPORT) begin
            state <= S_PK_RD;
          end
        end
        S_PK_RD: begin
          state <= S_PK_ACC;
        end
        S_PK_ACC: begin
          state <= idx_last ? S_BIN_RD : S_PK_RD;
        end
        S_BIN_RD: begin
          state <= S_BIN_LD;
        end
        S_BIN_LD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == '0) begin
            state <= idx_last ? S_IDLE : S_BIN_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        idx  <= '0;
        peak <= '0;
      end
      S_PK_ACC: begin
        if (count_rd > peak) begin
          peak <= count_rd;
        end
        idx <= idx_last ? '0 : idx + BIN_AW'(1);
      end
      S_BIN_LD: begin
        cur_cnt <= count_rd;
        num     <= NUM_W'(count_rd) * NUM_W'(max_bar_height);
        dsh     <= {1'b0, peak, {(BAR_W - 1){1'b0}}};
        quot    <= '0;
        step    <= STEP_W'(BAR_W - 1);
      end
      S_DIV: begin
        if (div_ge) begin
          num <= num - dsh;
        end
        dsh  <= dsh >> 1;
        quot <= quot_next;
        if (step == '0) begin
          result.word_length    <= LEN_W'(idx) + LEN_W'(1);
          result.word_count     <= cur_cnt;
          result.bar_length     <= bar;
          result.overflow_words <= overflow_count;
          result.last_bin       <= idx_last;
          idx                   <= idx + BIN_AW'(1);
        end else begin
          step <= step - STEP_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> !(rd_en && rd_addr == wr_addr))
    else $error("bin read meets pending write-back");

  a_wr_after_accept: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> state == S_IDLE || state == S_PK_RD)
    else $error("bin write-back outside the text path");

  a_report_busy: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.action == ACT_REPORT |=> busy)
    else $error("report item did not raise busy");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.last_bin |-> !busy && bin_valid == '0)
    else $error("counters not cleared after the last result");

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("result strobe held for more than one cycle");
`endif

endmodule

>>> tb/tb_word_length_histogram.sv
// Self-checking testbench for word_length_histogram: random text streams and reports,
// checked item by item against an in-bench model of the word counter and bar scaling.
// Depends on wlh_pkg and the word_length_histogram RTL.
`timescale 1ns / 1ps

module tb_word_length_histogram;
  import wlh_pkg::*;

  localparam int CLK_HALF        = 2;
  localparam int DRAIN_CYCLES    = 16;
  localparam int MAX_REPORTED    = 10;
  localparam int NUM_PHASES      = 8;
  localparam int PHASE_ITEMS     = 20;
  localparam int RESET_BAR       = 16;
  localparam int RUN_LIMIT_NS    = 4_000_000;

  // Tracks words and bin counts the way the block should, and holds the
  // report items it must produce.
  class histogram_scoreboard;
    logic [COUNT_WIDTH-1:0] bin_count[NUM_BINS];
    logic [COUNT_WIDTH-1:0] long_words;
    logic                   in_word;
    logic [LEN_W-1:0]       word_len;
    logic [BAR_W-1:0]       bar_height;
    out_item_t              report_q[$];
    int unsigned            mismatches;

    function new();
      bar_height = BAR_W'(RESET_BAR);
      mismatches = 0;
      clear_counts();
    endfunction

    function void clear_counts();
      foreach (bin_count[i]) bin_count[i] = '0;
      long_words = '0;
      in_word    = 1'b0;
      word_len   = '0;
    endfunction

    function bit is_break(logic [CHAR_W-1:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_NEWLINE;
    endfunction

    function logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function int unsigned pending();
      return report_q.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTED) $display("%s", msg);
    endfunction

    function void note_item(in_item_t it);
      logic [COUNT_WIDTH-1:0] peak;
      logic [NUM_W-1:0]       scaled;
      out_item_t              r;
      if (it.action == ACT_TEXT) begin
        if (is_break(it.char_code)) begin
          if (in_word) begin
            if (word_len >= 1 && word_len <= NUM_BINS)
              bin_count[word_len - 1] = bump(bin_count[word_len - 1]);
            else
              long_words = bump(long_words);
            in_word  = 1'b0;
            word_len = '0;
          end
        end else begin
          in_word = 1'b1;
          if (word_len != LEN_MAX) word_len = word_len + 1'b1;
        end
      end else begin
        peak = '0;
        foreach (bin_count[i])
          if (bin_count[i] > peak) peak = bin_count[i];
        for (int i = 0; i < NUM_BINS; i++) begin
          scaled = '0;
          if (bin_count[i] != 0 && peak != 0) begin
            scaled = (NUM_W'(bin_count[i]) * NUM_W'(bar_height)) / NUM_W'(peak);
            if (scaled == 0) scaled = 1;
          end
          r.word_length    = LEN_W'(i + 1);
          r.word_count     = bin_count[i];
          r.bar_length     = BAR_W'(scaled);
          r.overflow_words = long_words;
          r.last_bin       = (i == NUM_BINS - 1);
          report_q.push_back(r);
        end
        // An open word is dropped along with the counts.
        clear_counts();
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (report_q.size() == 0) begin
        flag($sformatf("unexpected result: len=%0d cnt=%0d bar=%0d ovf=%0d last=%0d",
                       got.word_length, got.word_count, got.bar_length,
                       got.overflow_words, got.last_bin));
        return;
      end
      exp = report_q.pop_front();
      if (got.word_length !== exp.word_length || got.word_count !== exp.word_count ||
          got.bar_length !== exp.bar_length || got.overflow_words !== exp.overflow_words ||
          got.last_bin !== exp.last_bin)
        flag($sformatf({"result mismatch: exp len=%0d cnt=%0d bar=%0d ovf=%0d last=%0d,",
                        " got len=%0d cnt=%0d bar=%0d ovf=%0d last=%0d"},
                       exp.word_length, exp.word_count, exp.bar_length,
                       exp.overflow_words, exp.last_bin,
                       got.word_length, got.word_count, got.bar_length,
                       got.overflow_words, got.last_bin));
    endfunction
  endclass

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             start       = 1'b0;
  in_item_t         cmd         = '0;
  logic             cfg_wr_en   = 1'b0;
  logic [BAR_W-1:0] cfg_wr_data = '0;
  logic             busy;
  logic             result_strobe;
  out_item_t        result;

  histogram_scoreboard sb = new();
  int unsigned         items_sent = 0;
  int unsigned         idle_pct   = 0;
  bit                  long_word_done = 1'b0;

  word_length_histogram u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .cmd           (cmd),
    .busy          (busy),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .result_strobe (result_strobe),
    .result        (result)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_strobe) sb.check_result(result);
      if (start && !busy) sb.note_item(cmd);
    end
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("Mismatches found");
    $finish;
  end

  // Called just after a rising edge; returns just after the edge that took the item.
  // Each cycle is idle with the phase's percentage, so gaps come out geometric.
  task automatic send_item(input logic act, input logic [CHAR_W-1:0] c);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= '{action: act, char_code: c};
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_bar_height(input int unsigned h);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= BAR_W'(h);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.bar_height = BAR_W'(h);
  endtask

  function automatic logic [CHAR_W-1:0] word_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(0, 255)); while (sb.is_break(c));
    return c;
  endfunction

  task automatic send_breaks(input int unsigned n);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0: send_item(ACT_TEXT, CHAR_SPACE);
        1: send_item(ACT_TEXT, CHAR_TAB);
        default: send_item(ACT_TEXT, CHAR_NEWLINE);
      endcase
    end
  endtask

  // One text: words of random content and length, then the end-of-text item.
  task automatic send_text();
    int unsigned n_words;
    int unsigned max_len;
    int unsigned len;
    n_words = $urandom_range(0, 4);
    case ($urandom_range(0, 3))
      0: max_len = 3;
      3: max_len = NUM_BINS + 8;
      default: max_len = NUM_BINS;
    endcase
    if ($urandom_range(0, 3) == 0) send_breaks($urandom_range(1, 3));
    for (int w = 0; w < n_words; w++) begin
      // Rare words at or near the length tracker's saturation point; the first word sent is always one.
      if (!long_word_done || $urandom_range(0, 59) == 0) begin
        len = $urandom_range(int'(LEN_MAX) - 2, int'(LEN_MAX) + 6);
        long_word_done = 1'b1;
      end else begin
        len = $urandom_range(1, max_len);
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat (len) send_item(ACT_TEXT, CHAR_W'($urandom_range(0, 255)));
      end else begin
        repeat (len) send_item(ACT_TEXT, word_char());
      end
      if (w != n_words - 1 || $urandom_range(0, 3) != 0)
        send_breaks(($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1);
    end
    send_item(ACT_REPORT, CHAR_W'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned phase_start;
    int unsigned h;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Report with nothing counted, at the reset bar height.
    send_item(ACT_REPORT, 8'h00);
    // Every separator, back-to-back separators, extreme bytes, an open word at the end.
    send_item(ACT_TEXT, 8'h00);
    send_item(ACT_TEXT, CHAR_SPACE);
    send_item(ACT_TEXT, 8'hFF);
    send_item(ACT_TEXT, 8'h7F);
    send_item(ACT_TEXT, CHAR_TAB);
    send_item(ACT_TEXT, CHAR_TAB);
    send_item(ACT_TEXT, 8'h41);
    send_item(ACT_TEXT, 8'h80);
    send_item(ACT_TEXT, 8'h55);
    send_item(ACT_TEXT, CHAR_NEWLINE);
    send_item(ACT_TEXT, 8'h5A);
    send_item(ACT_TEXT, CHAR_NEWLINE);
    send_item(ACT_TEXT, 8'hAA);
    send_item(ACT_REPORT, 8'hFF);
    wait_idle();
    set_bar_height(127);
    send_item(ACT_TEXT, 8'h7E);
    send_item(ACT_TEXT, CHAR_SPACE);
    send_item(ACT_TEXT, 8'h01);
    send_item(ACT_TEXT, 8'h02);
    send_item(ACT_TEXT, CHAR_NEWLINE);
    send_item(ACT_REPORT, 8'h20);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: h = 64;
        1: h = 1;
        3: h = 127;
        4: h = 0;
        6: h = 2;
        default: h = $urandom_range(0, 127);
      endcase
      set_bar_height(h);
      case (phase % 4)
        1: idle_pct = 62;
        3: idle_pct = 32;
        default: idle_pct = 0;
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_text();
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> word_length_histogram.f
hw/rtl/wlh_pkg.sv
hw/rtl/word_length_histogram.sv
tb/tb_word_length_histogram.sv
